/* src/kmnc_pkg.sv */
// Package for the k-means nearest-center block: sizes, item types, op and
// register codes, register clamp helper. No dependencies.
`timescale 1ns / 1ps

package kmnc_pkg;

  localparam int unsigned MAX_CENTERS = 16;
  localparam int unsigned MAX_DIMS    = 16;

  localparam int unsigned CIDX_W   = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
  localparam int unsigned DIDX_W   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int unsigned KCNT_W   = $clog2(MAX_CENTERS + 1);
  localparam int unsigned DCNT_W   = $clog2(MAX_DIMS + 1);
  localparam int unsigned COORD_AW = (MAX_CENTERS * MAX_DIMS > 1) ?
                                     $clog2(MAX_CENTERS * MAX_DIMS) : 1;
  localparam int unsigned CFG_W    = 5;
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned REG_IDX_W = 1;

  localparam logic [REG_IDX_W-1:0] REG_CENTERS = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_DIMS    = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD_COORD = 2'd0,
    OP_LOAD_ID    = 2'd1,
    OP_POINT      = 2'd2
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [3:0]  center_index;
    logic [3:0]  dim_index;
    logic [31:0] coord_value;
    logic [63:0] center_id;
  } kmnc_in_t;

  typedef struct packed {
    logic [63:0] nearest_id;
    logic [63:0] min_distance;
  } kmnc_out_t;

  // zero acts as one, large values saturate
  function automatic int unsigned clamp_reg(logic [CFG_W-1:0] v, int unsigned max);
    int unsigned r;
    r = 32'(v);
    if (r == 0) begin
      r = 1;
    end else if (r > max) begin
      r = max;
    end
    return r;
  endfunction

endpackage

/* src/kmnc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module kmnc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/kmeans_nearest_center.sv */
// K-means nearest-center top level: APB register port, command channel,
// center coordinate, id and distance-sum memories. Uses kmnc_pkg, kmnc_ram.
`timescale 1ns / 1ps

// Usage:
//   Program centers_in_use (0x0) and dims_in_use (0x4) over APB while idle.
//   Items enter when start_i is high and busy_o is low. Center coordinate
//   and center id loads finish in the accepting cycle; busy_o stays low.
//   A point coordinate raises busy_o: the block walks the centers in use
//   through one shared 32x32 multiplier, one center per cycle, doing a
//   read-modify-write of the distance-sum memory. After the last coordinate
//   of a point the block reads the id memory, then presents the result.
//   result_valid_o is high for exactly one cycle with nearest_id and
//   min_distance; the receiver cannot stall, so the result is taken then.
//   Reset clears control state, the coordinate count and the sum valid bits
//   and sets both registers to 1. Center memories hold garbage until loaded.
module kmeans_nearest_center
  import kmnc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  kmnc_in_t           item_i,
  output logic               busy_o,
  output logic               result_valid_o,
  output kmnc_out_t          result_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_LABEL = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  logic [1:0] state_q, state_d;

  logic [CFG_W-1:0] centers_q, dims_q;
  logic [REG_IDX_W-1:0] reg_idx;
  logic cfg_we;

  logic [DCNT_W-1:0] count_q;
  logic [DIDX_W-1:0] pos_d, pos_q;
  logic [DCNT_W-1:0] next_cnt;
  logic [DCNT_W-1:0] dims_k;
  logic [KCNT_W-1:0] k_d, k_q;
  logic              last_d, last_q;
  logic [31:0]       point_q;
  logic [KCNT_W-1:0] issue_q;
  logic              issuing;

  logic              v1_q, v2_q, v3_q;
  logic [CIDX_W-1:0] i1_q, i2_q, i3_q;
  logic [31:0]       absdiff_q;
  logic [63:0]       prod_d, prod_q;

  logic [MAX_CENTERS-1:0] sum_valid_q;
  logic [CIDX_W-1:0]      best_q;
  logic [63:0]            best_dist_q;
  logic [63:0]            sum_old, sum_new;
  logic                   final_wr;

  logic                accept;
  logic                coord_we, label_we;
  logic [COORD_AW-1:0] coord_waddr, coord_raddr;
  logic [31:0]         coord_rd;
  logic [63:0]         label_rd, sum_rd;

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1 -: REG_IDX_W];
  assign cfg_we  = psel & penable & pwrite & pready;

  always_comb begin
    case (reg_idx)
      REG_CENTERS: prdata = 32'(centers_q);
      REG_DIMS:    prdata = 32'(dims_q);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      centers_q <= CFG_W'(1);
      dims_q    <= CFG_W'(1);
    end else if (cfg_we) begin
      if (reg_idx == REG_CENTERS) begin
        centers_q <= pwdata[CFG_W-1:0];
      end
      if (reg_idx == REG_DIMS) begin
        dims_q <= pwdata[CFG_W-1:0];
      end
    end
  end

  // item decode
  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i & ~busy_o;

  assign coord_we = accept && (item_i.op == OP_LOAD_COORD) &&
                    (32'(item_i.center_index) < MAX_CENTERS) &&
                    (32'(item_i.dim_index) < MAX_DIMS);
  assign label_we = accept && (item_i.op == OP_LOAD_ID) &&
                    (32'(item_i.center_index) < MAX_CENTERS);
  assign coord_waddr = COORD_AW'(item_i.center_index) * COORD_AW'(MAX_DIMS) +
                       COORD_AW'(item_i.dim_index);

  assign pos_d    = (32'(count_q) >= MAX_DIMS) ? DIDX_W'(MAX_DIMS - 1) :
                                                 DIDX_W'(count_q);
  assign next_cnt = DCNT_W'(pos_d) + DCNT_W'(1);
  assign dims_k   = DCNT_W'(clamp_reg(dims_q, MAX_DIMS));
  assign k_d      = KCNT_W'(clamp_reg(centers_q, MAX_CENTERS));
  assign last_d   = (next_cnt >= dims_k);

  // center walk
  assign issuing     = (state_q == ST_RUN) && (issue_q < k_q);
  assign coord_raddr = COORD_AW'(issue_q[CIDX_W-1:0]) * COORD_AW'(MAX_DIMS) +
                       COORD_AW'(pos_q);

  assign prod_d  = 64'(absdiff_q) * 64'(absdiff_q);
  assign sum_old = sum_valid_q[i3_q] ? sum_rd : 64'd0;
  assign sum_new = sum_old + prod_q;
  assign final_wr = v3_q && ((KCNT_W'(i3_q) + KCNT_W'(1)) == k_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && item_i.op == OP_POINT) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (final_wr) begin
          state_d = last_q ? ST_LABEL : ST_IDLE;
        end
      end
      ST_LABEL: state_d = ST_OUT;
      ST_OUT:   state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      issue_q     <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      sum_valid_q <= '0;
      last_q      <= 1'b0;
      k_q         <= KCNT_W'(1);
      pos_q       <= '0;
    end else begin
      state_q <= state_d;
      if (accept && item_i.op == OP_POINT) begin
        count_q <= last_d ? '0 : next_cnt;
        pos_q   <= pos_d;
        last_q  <= last_d;
        k_q     <= k_d;
        issue_q <= '0;
      end else if (issuing) begin
        issue_q <= issue_q + KCNT_W'(1);
      end
      v1_q <= issuing;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (state_q == ST_OUT) begin
        sum_valid_q <= '0;
      end else if (v3_q) begin
        sum_valid_q[i3_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && item_i.op == OP_POINT) begin
      point_q <= item_i.coord_value;
    end
    i1_q      <= issue_q[CIDX_W-1:0];
    i2_q      <= i1_q;
    i3_q      <= i2_q;
    absdiff_q <= (coord_rd >= point_q) ? coord_rd - point_q : point_q - coord_rd;
    prod_q    <= prod_d;
    if (v3_q && last_q && (i3_q == '0 || sum_new < best_dist_q)) begin
      best_q      <= i3_q;
      best_dist_q <= sum_new;
    end
  end

  assign result_valid_o        = (state_q == ST_OUT);
  assign result_o.nearest_id   = label_rd;
  assign result_o.min_distance = best_dist_q;

  kmnc_ram #(
    .WIDTH (32),
    .DEPTH (MAX_CENTERS * MAX_DIMS)
  ) u_coord_ram (
    .clk_i   (clk_i),
    .we_i    (coord_we),
    .waddr_i (coord_waddr),
    .wdata_i (item_i.coord_value),
    .raddr_i (coord_raddr),
    .rdata_o (coord_rd)
  );

  kmnc_ram #(
    .WIDTH (64),
    .DEPTH (MAX_CENTERS)
  ) u_label_ram (
    .clk_i   (clk_i),
    .we_i    (label_we),
    .waddr_i (item_i.center_index[CIDX_W-1:0]),
    .wdata_i (item_i.center_id),
    .raddr_i (best_q),
    .rdata_o (label_rd)
  );

  kmnc_ram #(
    .WIDTH (64),
    .DEPTH (MAX_CENTERS)
  ) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (v3_q),
    .waddr_i (i3_q),
    .wdata_i (sum_new),
    .raddr_i (i2_q),
    .rdata_o (sum_rd)
  );

endmodule

/* verif/kmeans_nearest_center_test.sv */
// Self-checking testbench for kmeans_nearest_center: command items, APB registers, result checks.
// Depends on kmnc_pkg and the kmeans_nearest_center RTL; needs nothing else.
`timescale 1ns / 1ps

module kmeans_nearest_center_test;
  import kmnc_pkg::*;

  localparam logic [1:0]  OP_UNUSED     = 2'd3;
  localparam int unsigned SETTLE_CYCLES = 48;
  localparam int unsigned STALL_LIMIT   = 2000;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               start_i;
  kmnc_in_t           item_i;
  logic               busy_o;
  logic               result_valid_o;
  kmnc_out_t          result_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  kmeans_nearest_center u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .item_i         (item_i),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // predictor state
  logic [31:0]      center_coord_m [MAX_CENTERS][MAX_DIMS];
  logic [63:0]      center_label_m [MAX_CENTERS];
  logic [63:0]      dist_sum_m [MAX_CENTERS];
  int unsigned      coord_seen;
  logic [CFG_W-1:0] centers_reg;
  logic [CFG_W-1:0] dims_reg;
  kmnc_out_t        nearest_pending [$];

  int          errors = 0;
  int          idle_pct = 27;
  int unsigned quiet_cycles = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int unsigned reg_count(logic [CFG_W-1:0] v, int unsigned max);
    return (v == '0) ? 1 : ((32'(v) > max) ? max : 32'(v));
  endfunction

  function automatic logic [31:0] coord_pattern();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return 32'd0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic kmnc_in_t make_item(logic [1:0] op, logic [3:0] ci, logic [3:0] di,
                                         logic [31:0] v, logic [63:0] id);
    kmnc_in_t it;
    it.op           = op_e'(op);
    it.center_index = ci;
    it.dim_index    = di;
    it.coord_value  = v;
    it.center_id    = id;
    return it;
  endfunction

  task automatic apply_item(kmnc_in_t it);
    int unsigned k, dims, pos, best, i;
    logic [63:0] diff;
    kmnc_out_t   r;
    case (it.op)
      OP_LOAD_COORD: center_coord_m[it.center_index][it.dim_index] = it.coord_value;
      OP_LOAD_ID:    center_label_m[it.center_index] = it.center_id;
      OP_POINT: begin
        k    = reg_count(centers_reg, MAX_CENTERS);
        dims = reg_count(dims_reg, MAX_DIMS);
        pos  = (coord_seen >= MAX_DIMS) ? MAX_DIMS - 1 : coord_seen;
        for (i = 0; i < k; i++) begin
          diff = {32'd0, center_coord_m[i][pos]} - {32'd0, it.coord_value};
          dist_sum_m[i] = dist_sum_m[i] + diff * diff;
        end
        coord_seen = pos + 1;
        if (coord_seen >= dims) begin
          best = 0;
          for (i = 1; i < k; i++) begin
            if (dist_sum_m[i] < dist_sum_m[best]) best = i;
          end
          r.nearest_id   = center_label_m[best];
          r.min_distance = dist_sum_m[best];
          nearest_pending.push_back(r);
          for (i = 0; i < MAX_CENTERS; i++) dist_sum_m[i] = '0;
          coord_seen = 0;
        end
      end
      default: ;
    endcase
  endtask

  // called right after a rising edge; leaves start_i high for a following item
  task automatic send_item(kmnc_in_t it);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    item_i  <= it;
    do @(posedge clk_i); while (busy_o);
    apply_item(it);
  endtask

  task automatic settle();
    start_i <= 1'b0;
    while (nearest_pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    logic [PADDR_W-1:0] addr;
    addr = PADDR_W'(idx) << 2;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_CENTERS) centers_reg = value;
    else dims_reg = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== 32'(value)) begin
      $display("%0t: register 0x%h read back: expected %h, actual %h",
               $time, addr, 32'(value), prdata);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_sizes(logic [CFG_W-1:0] k, logic [CFG_W-1:0] d);
    settle();
    write_reg(REG_CENTERS, k);
    write_reg(REG_DIMS, d);
  endtask

  task automatic test_load_centers();
    int c, d;
    for (c = 0; c < MAX_CENTERS; c++) begin
      for (d = 0; d < MAX_DIMS; d++) begin
        send_item(make_item(OP_LOAD_COORD, 4'(c), 4'(d), coord_pattern(), rand64()));
      end
      send_item(make_item(OP_LOAD_ID, 4'(c), 4'($urandom), $urandom, rand64()));
    end
  endtask

  task automatic test_extremes_and_ties();
    set_sizes(5'd2, 5'd2);
    send_item(make_item(OP_LOAD_COORD, 4'd0, 4'd0, 32'd0, rand64()));
    send_item(make_item(OP_LOAD_COORD, 4'd0, 4'd1, 32'd0, rand64()));
    send_item(make_item(OP_LOAD_COORD, 4'd1, 4'd0, '1, rand64()));
    send_item(make_item(OP_LOAD_COORD, 4'd1, 4'd1, '1, rand64()));
    send_item(make_item(OP_LOAD_ID, 4'd0, 4'd15, '1, 64'd0));
    send_item(make_item(OP_LOAD_ID, 4'd1, 4'd0, 32'd0, '1));
    send_item(make_item(OP_POINT, 4'd15, 4'd15, '1, '1));
    send_item(make_item(OP_POINT, 4'd0, 4'd0, '1, 64'd0));
    send_item(make_item(OP_POINT, 4'd0, 4'd0, 32'd0, 64'd0));
    send_item(make_item(OP_POINT, 4'd15, 4'd0, 32'd0, '1));
    // equal distances on both centers, lower index must win
    send_item(make_item(OP_POINT, 4'd3, 4'd9, '1, rand64()));
    send_item(make_item(OP_POINT, 4'd9, 4'd3, 32'd0, rand64()));
    // unused op is dropped
    send_item(make_item(OP_UNUSED, '1, '1, '1, '1));
    send_item(make_item(OP_UNUSED, '0, '0, '0, '0));
  endtask

  task automatic test_register_limits();
    set_sizes(5'd0, 5'd0);
    send_item(make_item(OP_POINT, 4'd0, 4'd0, coord_pattern(), rand64()));
    set_sizes(5'd31, 5'd31);
    send_item(make_item(OP_POINT, 4'd0, 4'd0, '1, rand64()));
    send_item(make_item(OP_POINT, 4'd0, 4'd0, $urandom, rand64()));
  endtask

  task automatic test_midpoint_change();
    // point from the previous test is two coordinates in
    set_sizes(5'd17, 5'd3);
    send_item(make_item(OP_POINT, 4'd0, 4'd0, $urandom, rand64()));
    set_sizes(5'd5, 5'd8);
    send_item(make_item(OP_POINT, 4'd0, 4'd0, $urandom, rand64()));
    set_sizes(5'd5, 5'd1);
    send_item(make_item(OP_POINT, 4'd0, 4'd0, $urandom, rand64()));
  endtask

  task automatic send_random_item();
    kmnc_in_t    it;
    int unsigned r, pos;
    it  = make_item(OP_POINT, 4'($urandom), 4'($urandom), coord_pattern(), rand64());
    r   = $urandom_range(99);
    pos = (coord_seen >= MAX_DIMS) ? MAX_DIMS - 1 : coord_seen;
    if (r < 75) begin
      if ($urandom_range(2) == 0)
        it.coord_value = center_coord_m[$urandom_range(MAX_CENTERS - 1)][pos];
    end else if (r < 88) begin
      it.op = OP_LOAD_COORD;
      if ($urandom_range(2) == 0)
        it.coord_value = center_coord_m[$urandom_range(MAX_CENTERS - 1)][it.dim_index];
    end else if (r < 95) begin
      it.op = OP_LOAD_ID;
    end else begin
      it.op = op_e'(OP_UNUSED);
    end
    send_item(it);
  endtask

  task automatic test_random_phases();
    logic [CFG_W-1:0] k_set [12];
    logic [CFG_W-1:0] d_set [12];
    int p, n;
    k_set = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd16, 5'd1, 5'd4, 5'd0, 5'd0, 5'd0, 5'd8};
    d_set = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd2, 5'd1, 5'd16, 5'd3, 5'd0, 5'd0, 5'd0, 5'd4};
    for (p = 8; p < 11; p++) begin
      k_set[p] = 5'($urandom_range(0, 31));
      d_set[p] = 5'($urandom_range(0, 31));
    end
    for (p = 0; p < 12; p++) begin
      set_sizes(k_set[p], d_set[p]);
      idle_pct = (p == 11) ? 0 : 27;
      for (n = 0; n < ((p == 11) ? 200 : 65); n++) send_random_item();
    end
    idle_pct = 27;
  endtask

  always @(posedge clk_i) begin
    kmnc_out_t want;
    if (rst_ni === 1'b1 && result_valid_o === 1'b1) begin
      if (nearest_pending.size() == 0) begin
        $display("%0t: result with none expected: id %h distance %h",
                 $time, result_o.nearest_id, result_o.min_distance);
        errors++;
      end else begin
        want = nearest_pending.pop_front();
        if (result_o.nearest_id !== want.nearest_id) begin
          $display("%0t: nearest_id expected %h, actual %h",
                   $time, want.nearest_id, result_o.nearest_id);
          errors++;
        end
        if (result_o.min_distance !== want.min_distance) begin
          $display("%0t: min_distance expected %h, actual %h",
                   $time, want.min_distance, result_o.min_distance);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start_i === 1'b1 && busy_o === 1'b0) || result_valid_o === 1'b1 || psel === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("kmeans_nearest_center test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni  <= 1'b0;
    start_i <= 1'b0;
    item_i  <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    centers_reg = 5'd1;
    dims_reg    = 5'd1;
    coord_seen  = 0;
    for (int i = 0; i < MAX_CENTERS; i++) dist_sum_m[i] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_load_centers();
    test_extremes_and_ties();
    test_register_limits();
    test_midpoint_change();
    test_random_phases();
    settle();
    if (errors == 0) begin
      $display("kmeans_nearest_center test passed");
    end else begin
      $display("kmeans_nearest_center test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/kmnc_pkg.sv
src/kmnc_ram.sv
src/kmeans_nearest_center.sv
verif/kmeans_nearest_center_test.sv
